// ===== hw/rtl/rzs_pkg.sv =====
// Package: shared types and constants for the RGB zlib stored-stream encoder.
`timescale 1ns / 1ps
package rzs_pkg;

  localparam int MAX_SIDE    = 4096;
  localparam int QUEUE_DEPTH = 4;
  localparam int OUT_DEPTH   = 2;

  localparam int SIDE_W    = 13;
  localparam int IDX_W     = 12;
  localparam int PIX_W     = 24;
  localparam int RAW_W     = 26;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;

  localparam logic [7:0]  ZLIB_CMF  = 8'h78;
  localparam logic [7:0]  ZLIB_FLG  = 8'h01;
  localparam logic [16:0] ADLER_MOD = 17'd65521;
  localparam logic [15:0] BLOCK_MAX = 16'hFFFF;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_ZHDR,
    BK_BHDR,
    BK_RAW,
    BK_DATA,
    BK_TRAIL
  } rzs_back_state_e;

  // One classified pixel, front to back.
  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             open_stream;
    logic             row_start;
    logic             last_pixel;
  } rzs_entry_t;

  // One result byte, back to output queue.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       item_last;
    logic       stream_end;
  } rzs_out_t;

endpackage

// ===== hw/rtl/rzs_fifo.sv =====
// Small register-based FIFO used for the request queue and the result queue.
`timescale 1ns / 1ps
module rzs_fifo #(
  parameter int Width = 8,
  parameter int Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_en_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             rd_en_i,
  output logic [Width-1:0] rdata_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wptr_q, rptr_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_wr, do_rd;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign do_wr   = wr_en_i && !full_o;
  assign do_rd   = rd_en_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_wr) begin
        wptr_q <= (wptr_q == LastPtr) ? '0 : wptr_q + 1'b1;
      end
      if (do_rd) begin
        rptr_q <= (rptr_q == LastPtr) ? '0 : rptr_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/rzs_front.sv =====
// Front end: config registers, raster position tracking and pixel classification.
`timescale 1ns / 1ps
module rzs_front #(
  parameter int MaxSide = rzs_pkg::MAX_SIDE
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [rzs_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [rzs_pkg::SIDE_W-1:0]      cfg_data_i,
  input  logic                            push_i,
  input  logic [rzs_pkg::PIX_W-1:0]       pixel_rgb_i,
  input  logic                            q_full_i,
  output logic                            q_push_o,
  output rzs_pkg::rzs_entry_t             q_entry_o,
  output logic [rzs_pkg::RAW_W-1:0]       raw_total_o
);

  localparam logic [rzs_pkg::SIDE_W-1:0] MaxSideV = rzs_pkg::SIDE_W'(MaxSide);

  logic [rzs_pkg::SIDE_W-1:0] width_q, height_q, side_clamped;
  logic [rzs_pkg::IDX_W-1:0]  col_q, row_q;
  logic                       open_q;
  logic [rzs_pkg::RAW_W-1:0]  raw_total_q;
  logic [14:0]                row_bytes;
  logic [27:0]                prod;
  logic                       accept, col_wrap, row_wrap;

  assign cfg_ready_o = 1'b1;
  assign accept      = push_i && !q_full_i;
  assign q_push_o    = accept;

  assign col_wrap = ({1'b0, col_q} + 13'd1) >= width_q;
  assign row_wrap = ({1'b0, row_q} + 13'd1) >= height_q;

  assign q_entry_o.pixel       = pixel_rgb_i;
  assign q_entry_o.open_stream = !open_q;
  assign q_entry_o.row_start   = (col_q == '0);
  assign q_entry_o.last_pixel  = col_wrap && row_wrap;

  always_comb begin
    if (cfg_data_i == '0) begin
      side_clamped = 13'd1;
    end else if (cfg_data_i > MaxSideV) begin
      side_clamped = MaxSideV;
    end else begin
      side_clamped = cfg_data_i;
    end
  end

  // raw bytes per image: height * (1 + 3 * width)
  assign row_bytes   = {2'b0, width_q} + {1'b0, width_q, 1'b0} + 15'd1;
  assign prod        = {15'b0, height_q} * {13'b0, row_bytes};
  assign raw_total_o = raw_total_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q     <= 13'd1;
      height_q    <= 13'd1;
      col_q       <= '0;
      row_q       <= '0;
      open_q      <= 1'b0;
      raw_total_q <= '0;
    end else begin
      raw_total_q <= prod[rzs_pkg::RAW_W-1:0];
      if (cfg_valid_i && !open_q) begin
        if (cfg_index_i == rzs_pkg::CFG_WIDTH) begin
          width_q <= side_clamped;
        end else if (cfg_index_i == rzs_pkg::CFG_HEIGHT) begin
          height_q <= side_clamped;
        end
      end
      if (accept) begin
        if (col_wrap && row_wrap) begin
          col_q  <= '0;
          row_q  <= '0;
          open_q <= 1'b0;
        end else begin
          open_q <= 1'b1;
          if (col_wrap) begin
            col_q <= '0;
            row_q <= row_q + 1'b1;
          end else begin
            col_q <= col_q + 1'b1;
          end
        end
      end
    end
  end

endmodule

// ===== hw/rtl/rzs_back.sv =====
// Back end: byte sequencer for zlib header, stored block headers, raw data and Adler-32.
`timescale 1ns / 1ps
module rzs_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      q_empty_i,
  input  rzs_pkg::rzs_entry_t       q_entry_i,
  output logic                      q_pop_o,
  input  logic [rzs_pkg::RAW_W-1:0] raw_total_i,
  input  logic                      out_full_i,
  output logic                      out_push_o,
  output rzs_pkg::rzs_out_t         out_data_o
);

  localparam logic [1:0] RawFilter = 2'd0;
  localparam logic [1:0] RawRed    = 2'd1;
  localparam logic [1:0] RawGreen  = 2'd2;
  localparam logic [1:0] RawBlue   = 2'd3;

  rzs_pkg::rzs_back_state_e state_q, state_d;
  logic [2:0]                cnt_q, cnt_d;
  logic [1:0]                rsel_q, rsel_d;
  logic [rzs_pkg::PIX_W-1:0] pix_q, pix_d;
  logic                      last_q, last_d;
  logic [15:0]               blk_q, blk_d;
  logic [rzs_pkg::RAW_W-1:0] raw_q, raw_d;
  logic [15:0]               lo_q, lo_d, hi_q, hi_d;

  logic        ok, data_go, done;
  logic        final_blk;
  logic [15:0] blk_len, blk_inv;
  logic [7:0]  raw_byte;
  logic [16:0] lo_sum, lo_red, hi_sum, hi_red;

  assign ok        = !out_full_i;
  assign final_blk = (raw_q[rzs_pkg::RAW_W-1:16] == '0);
  assign blk_len   = final_blk ? raw_q[15:0] : rzs_pkg::BLOCK_MAX;
  assign blk_inv   = ~blk_len;

  always_comb begin
    unique case (rsel_q)
      RawFilter: raw_byte = 8'h00;
      RawRed:    raw_byte = pix_q[23:16];
      RawGreen:  raw_byte = pix_q[15:8];
      RawBlue:   raw_byte = pix_q[7:0];
      default:   raw_byte = 8'h00;
    endcase
  end

  assign lo_sum = {1'b0, lo_q} + {9'b0, raw_byte};
  assign lo_red = (lo_sum >= rzs_pkg::ADLER_MOD) ? lo_sum - rzs_pkg::ADLER_MOD : lo_sum;
  assign hi_sum = {1'b0, hi_q} + {1'b0, lo_red[15:0]};
  assign hi_red = (hi_sum >= rzs_pkg::ADLER_MOD) ? hi_sum - rzs_pkg::ADLER_MOD : hi_sum;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    rsel_d     = rsel_q;
    pix_d      = pix_q;
    last_d     = last_q;
    blk_d      = blk_q;
    raw_d      = raw_q;
    lo_d       = lo_q;
    hi_d       = hi_q;
    out_push_o = 1'b0;
    out_data_o = '0;
    q_pop_o    = 1'b0;
    data_go    = 1'b0;
    done       = 1'b0;

    unique case (state_q)
      rzs_pkg::BK_IDLE: begin
        done = 1'b1;
      end
      rzs_pkg::BK_ZHDR: begin
        if (ok) begin
          out_push_o          = 1'b1;
          out_data_o.out_byte = (cnt_q == 3'd0) ? rzs_pkg::ZLIB_CMF : rzs_pkg::ZLIB_FLG;
          if (cnt_q == 3'd0) begin
            cnt_d = 3'd1;
          end else begin
            cnt_d   = 3'd0;
            state_d = rzs_pkg::BK_RAW;
          end
        end
      end
      rzs_pkg::BK_BHDR: begin
        if (ok) begin
          out_push_o = 1'b1;
          unique case (cnt_q)
            3'd1:    out_data_o.out_byte = blk_len[7:0];
            3'd2:    out_data_o.out_byte = blk_len[15:8];
            3'd3:    out_data_o.out_byte = blk_inv[7:0];
            3'd4:    out_data_o.out_byte = blk_inv[15:8];
            default: out_data_o.out_byte = {7'b0, final_blk};
          endcase
          if (cnt_q == 3'd4) begin
            blk_d   = blk_len;
            cnt_d   = 3'd0;
            state_d = rzs_pkg::BK_DATA;
          end else begin
            cnt_d = cnt_q + 3'd1;
          end
        end
      end
      rzs_pkg::BK_RAW: begin
        if (ok) begin
          if (blk_q == '0) begin
            out_push_o          = 1'b1;
            out_data_o.out_byte = {7'b0, final_blk};
            cnt_d               = 3'd1;
            state_d             = rzs_pkg::BK_BHDR;
          end else begin
            data_go = 1'b1;
          end
        end
      end
      rzs_pkg::BK_DATA: begin
        if (ok) begin
          data_go = 1'b1;
        end
      end
      rzs_pkg::BK_TRAIL: begin
        if (ok) begin
          out_push_o = 1'b1;
          unique case (cnt_q[1:0])
            2'd0:    out_data_o.out_byte = hi_q[15:8];
            2'd1:    out_data_o.out_byte = hi_q[7:0];
            2'd2:    out_data_o.out_byte = lo_q[15:8];
            default: out_data_o.out_byte = lo_q[7:0];
          endcase
          if (cnt_q == 3'd3) begin
            out_data_o.item_last  = 1'b1;
            out_data_o.stream_end = 1'b1;
            done                  = 1'b1;
          end else begin
            cnt_d = cnt_q + 3'd1;
          end
        end
      end
      default: begin
        state_d = rzs_pkg::BK_IDLE;
      end
    endcase

    if (data_go) begin
      out_push_o          = 1'b1;
      out_data_o.out_byte = raw_byte;
      if (blk_q != '0) begin
        blk_d = blk_q - 16'd1;
      end
      if (raw_q != '0) begin
        raw_d = raw_q - 1'b1;
      end
      lo_d = lo_red[15:0];
      hi_d = hi_red[15:0];
      if (rsel_q == RawBlue) begin
        if (last_q) begin
          cnt_d   = 3'd0;
          state_d = rzs_pkg::BK_TRAIL;
        end else begin
          out_data_o.item_last = 1'b1;
          done                 = 1'b1;
        end
      end else begin
        rsel_d  = rsel_q + 2'd1;
        state_d = rzs_pkg::BK_RAW;
      end
    end

    if (done) begin
      if (!q_empty_i) begin
        q_pop_o = 1'b1;
        pix_d   = q_entry_i.pixel;
        last_d  = q_entry_i.last_pixel;
        rsel_d  = q_entry_i.row_start ? RawFilter : RawRed;
        cnt_d   = 3'd0;
        if (q_entry_i.open_stream) begin
          raw_d   = raw_total_i;
          blk_d   = '0;
          lo_d    = 16'd1;
          hi_d    = 16'd0;
          state_d = rzs_pkg::BK_ZHDR;
        end else begin
          state_d = rzs_pkg::BK_RAW;
        end
      end else begin
        state_d = rzs_pkg::BK_IDLE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rzs_pkg::BK_IDLE;
      cnt_q   <= '0;
      rsel_q  <= '0;
      last_q  <= 1'b0;
      blk_q   <= '0;
      raw_q   <= '0;
      lo_q    <= 16'd1;
      hi_q    <= 16'd0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      rsel_q  <= rsel_d;
      last_q  <= last_d;
      blk_q   <= blk_d;
      raw_q   <= raw_d;
      lo_q    <= lo_d;
      hi_q    <= hi_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pix_q <= pix_d;
  end

endmodule

// ===== hw/rtl/rgb_zlib_stored_stream_encoder_top.sv =====
// Top level: RGB pixels in, zlib stored stream with Adler-32 trailer out.
`timescale 1ns / 1ps
// Pixels enter through a queue-style port (push/full) in raster order and bytes
// leave through a queue-style port (empty/pop). The back sequencer emits one stream
// byte per cycle while the result queue has room. A pixel yields 3 bytes, 4 at the
// start of a row, plus 2 for the zlib header on the first pixel, 5 per stored block
// header (one per 65535 raw bytes) and 4 for the Adler-32 trailer after the last
// pixel; the sustained output is about (1 + 3*width)/width bytes per pixel.
// A 4-deep request queue sits between classification and the sequencer, and a
// 2-deep result queue at the output. Image width and height writes are ignored
// while a stream is open; zero is taken as 1 and values above MaxSide as MaxSide.
module rgb_zlib_stored_stream_encoder_top #(
  parameter int MaxSide    = rzs_pkg::MAX_SIDE,
  parameter int QueueDepth = rzs_pkg::QUEUE_DEPTH,
  parameter int OutDepth   = rzs_pkg::OUT_DEPTH
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [rzs_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [rzs_pkg::SIDE_W-1:0]    cfg_data_i,
  input  logic                          push,
  output logic                          full,
  input  logic [rzs_pkg::PIX_W-1:0]     pixel_rgb_i,
  output logic                          empty,
  input  logic                          pop,
  output logic [7:0]                    out_byte_o,
  output logic                          item_last_o,
  output logic                          stream_end_o
);

  rzs_pkg::rzs_entry_t       fq_wdata, fq_rdata;
  rzs_pkg::rzs_out_t         oq_wdata, oq_rdata;
  logic                      fq_push, fq_pop, fq_empty;
  logic                      oq_push, oq_full;
  logic [rzs_pkg::RAW_W-1:0] raw_total;

  rzs_front #(
    .MaxSide(MaxSide)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .push_i     (push),
    .pixel_rgb_i(pixel_rgb_i),
    .q_full_i   (full),
    .q_push_o   (fq_push),
    .q_entry_o  (fq_wdata),
    .raw_total_o(raw_total)
  );

  rzs_fifo #(
    .Width($bits(rzs_pkg::rzs_entry_t)),
    .Depth(QueueDepth)
  ) u_req_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_en_i(fq_push),
    .wdata_i(fq_wdata),
    .rd_en_i(fq_pop),
    .rdata_o(fq_rdata),
    .full_o (full),
    .empty_o(fq_empty)
  );

  rzs_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_empty_i  (fq_empty),
    .q_entry_i  (fq_rdata),
    .q_pop_o    (fq_pop),
    .raw_total_i(raw_total),
    .out_full_i (oq_full),
    .out_push_o (oq_push),
    .out_data_o (oq_wdata)
  );

  rzs_fifo #(
    .Width($bits(rzs_pkg::rzs_out_t)),
    .Depth(OutDepth)
  ) u_res_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_en_i(oq_push),
    .wdata_i(oq_wdata),
    .rd_en_i(pop),
    .rdata_o(oq_rdata),
    .full_o (oq_full),
    .empty_o(empty)
  );

  assign out_byte_o   = oq_rdata.out_byte;
  assign item_last_o  = oq_rdata.item_last;
  assign stream_end_o = oq_rdata.stream_end;

endmodule
